FILE: rtl/mpss_pkg.sv
package mpss_pkg;

  localparam int RES_W = 5;
  localparam int RAND_W = 31;
  localparam int OP_W = 2;
  localparam int S_DATA_W = 48;
  localparam int M_DATA_W = 16;

  localparam logic [OP_W-1:0] OP_TRAIN = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_NEXT  = 2'd2;

  typedef enum logic [7:0] {
    S_CLEAR = 8'b0000_0001,
    S_IDLE  = 8'b0000_0010,
    S_TUPD  = 8'b0000_0100,
    S_RROW  = 8'b0000_1000,
    S_DIV   = 8'b0001_0000,
    S_SCAN  = 8'b0010_0000,
    S_EMIT  = 8'b0100_0000,
    S_SPARE = 8'b1000_0000
  } state_t;

endpackage

FILE: rtl/mpss_ram.sv
module mpss_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/mpss_mod.sv
module mpss_mod #(
  parameter int DW = 26
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        go,
  input  logic [mpss_pkg::RAND_W-1:0] dividend,
  input  logic [DW-1:0]               divisor,
  output logic                        done,
  output logic [DW-1:0]               rem
);
  import mpss_pkg::*;

  localparam int CW = $clog2(RAND_W + 1);

  logic          busy;
  logic [CW-1:0] cnt;
  logic [RAND_W-1:0] dvd;
  logic [DW-1:0] d;
  logic [DW:0]   trial;
  logic [DW:0]   diff;

  assign trial = {rem, dvd[RAND_W-1]};
  assign diff = trial - {1'b0, d};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        busy <= 1'b1;
        cnt <= '0;
        dvd <= dividend;
        d <= divisor;
        rem <= '0;
      end else if (busy) begin
        dvd <= {dvd[RAND_W-2:0], 1'b0};
        if (trial >= {1'b0, d}) begin
          rem <= diff[DW-1:0];
        end else begin
          rem <= trial[DW-1:0];
        end
        cnt <= cnt + 1'b1;
        if (cnt == CW'(RAND_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

FILE: rtl/markov_pair_sequence_sampler.sv
// Second-order Markov sampler over residue pairs. After reset the count memories are
// cleared one entry per cycle, 2^(3*ceil(log2(ALPHABET_SIZE))) entries (32768 by default),
// while no request is taken. A training request updates the counts and then returns to idle.
// A start or next request runs a 31-bit bit-serial modulo of the random value by the total
// count and then walks over the count memory, one entry per cycle, stopping at the picked entry.
// An empty distribution returns an error result right away. Requests are handled one at a
// time; a result waits in the output register while the next request is taken, but the
// result of that request is held until the waiting one is taken.
module markov_pair_sequence_sampler #(
  parameter int ALPHABET_SIZE = 32,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // residue_a, residue_b, residue_c, random_value, zero fill
  input  logic [mpss_pkg::S_DATA_W-1:0] s_tdata,
  // operation
  input  logic [mpss_pkg::OP_W-1:0]     s_tuser,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // residue_first, residue_second, zero fill
  output logic [mpss_pkg::M_DATA_W-1:0] m_tdata,
  // empty_error
  output logic                          m_tuser
);
  import mpss_pkg::*;

  localparam int AW = $clog2(ALPHABET_SIZE);
  localparam int PW = 2 * AW;
  localparam int TW = 3 * AW;
  localparam int RW = COUNT_WIDTH + AW;
  localparam int DW = COUNT_WIDTH + PW;

  state_t state;

  logic [RES_W-1:0]  in_a, in_b, in_c;
  logic [RAND_W-1:0] in_rnd;
  logic [AW-1:0]     ra, rb, rc;
  logic              res_ok;
  logic              accept;

  logic [TW-1:0] clr;
  logic [TW-1:0] t_idx;
  logic [PW-1:0] t_ab, t_bc;
  logic [OP_W-1:0] op_q;
  logic [RAND_W-1:0] rnd_q;
  logic [DW-1:0] start_total;
  logic [PW-1:0] cur_pair;
  logic [PW-1:0] cnt, pend_idx;
  logic          rd_pend;
  logic [DW-1:0] cum, cum_next, r_q;
  logic [RES_W-1:0] res_first, res_second;
  logic          res_err;

  logic                   clearing, upd_we, sat;
  logic [TW-1:0]          tr_waddr, tr_raddr;
  logic [PW-1:0]          st_waddr, st_raddr, rw_waddr, rw_raddr;
  logic [COUNT_WIDTH-1:0] tr_wdata, tr_rdata, st_wdata, st_rdata, scan_data;
  logic [RW-1:0]          rw_wdata, rw_rdata;

  logic          div_go, div_done;
  logic [DW-1:0] div_d, div_rem;

  assign in_a = s_tdata[RES_W-1:0];
  assign in_b = s_tdata[2*RES_W-1:RES_W];
  assign in_c = s_tdata[3*RES_W-1:2*RES_W];
  assign in_rnd = s_tdata[3*RES_W +: RAND_W];
  assign ra = AW'(in_a);
  assign rb = AW'(in_b);
  assign rc = AW'(in_c);
  assign res_ok = (32'(in_a) < ALPHABET_SIZE) && (32'(in_b) < ALPHABET_SIZE) &&
                  (32'(in_c) < ALPHABET_SIZE);

  assign s_tready = (state == S_IDLE);
  assign accept = s_tvalid && s_tready;

  assign clearing = (state == S_CLEAR);
  assign sat = (tr_rdata == '1) || (st_rdata == '1);
  assign upd_we = (state == S_TUPD) && !sat;

  assign tr_waddr = clearing ? clr : t_idx;
  assign st_waddr = clearing ? clr[PW-1:0] : t_bc;
  assign rw_waddr = clearing ? clr[PW-1:0] : t_ab;
  assign tr_wdata = clearing ? '0 : tr_rdata + 1'b1;
  assign st_wdata = clearing ? '0 : st_rdata + 1'b1;
  assign rw_wdata = clearing ? '0 : rw_rdata + 1'b1;

  assign tr_raddr = (state == S_SCAN) ? {cur_pair, cnt[AW-1:0]} : {ra, rb, rc};
  assign st_raddr = (state == S_SCAN) ? cnt : {rb, rc};
  assign rw_raddr = (s_tuser == OP_NEXT) ? cur_pair : {ra, rb};

  assign scan_data = (op_q == OP_START) ? st_rdata : tr_rdata;
  assign cum_next = cum + DW'(scan_data);

  assign div_go = ((state == S_IDLE) && accept && (s_tuser == OP_START) &&
                   (start_total != '0)) ||
                  ((state == S_RROW) && (rw_rdata != '0));
  assign div_d = (state == S_RROW) ? DW'(rw_rdata) : start_total;

  mpss_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(2 ** TW)) u_trans (
    .clk(clk), .we(clearing || upd_we), .waddr(tr_waddr), .wdata(tr_wdata),
    .raddr(tr_raddr), .rdata(tr_rdata)
  );

  mpss_ram #(.WIDTH(COUNT_WIDTH), .DEPTH(2 ** PW)) u_start (
    .clk(clk), .we(clearing || upd_we), .waddr(st_waddr), .wdata(st_wdata),
    .raddr(st_raddr), .rdata(st_rdata)
  );

  mpss_ram #(.WIDTH(RW), .DEPTH(2 ** PW)) u_row (
    .clk(clk), .we(clearing || upd_we), .waddr(rw_waddr), .wdata(rw_wdata),
    .raddr(rw_raddr), .rdata(rw_rdata)
  );

  mpss_mod #(.DW(DW)) u_mod (
    .clk(clk), .rst(rst), .go(div_go),
    .dividend((state == S_IDLE) ? in_rnd : rnd_q),
    .divisor(div_d), .done(div_done), .rem(div_rem)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
      clr <= '0;
      start_total <= '0;
      cur_pair <= '0;
      m_tvalid <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      if ((state == S_EMIT) && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_CLEAR: begin
          clr <= clr + 1'b1;
          if (clr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            op_q <= s_tuser;
            rnd_q <= in_rnd;
            t_idx <= {ra, rb, rc};
            t_ab <= {ra, rb};
            t_bc <= {rb, rc};
            case (s_tuser)
              OP_TRAIN: begin
                if (res_ok) begin
                  state <= S_TUPD;
                end
              end
              OP_START: begin
                if (start_total == '0) begin
                  res_first <= '0;
                  res_second <= '0;
                  res_err <= 1'b1;
                  state <= S_EMIT;
                end else begin
                  state <= S_DIV;
                end
              end
              OP_NEXT: state <= S_RROW;
              default: state <= S_IDLE;
            endcase
          end
        end
        S_TUPD: begin
          if (!sat) begin
            start_total <= start_total + 1'b1;
          end
          state <= S_IDLE;
        end
        S_RROW: begin
          if (rw_rdata == '0) begin
            res_first <= '0;
            res_second <= '0;
            res_err <= 1'b1;
            state <= S_EMIT;
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (div_done) begin
            r_q <= div_rem;
            cnt <= '0;
            rd_pend <= 1'b0;
            cum <= '0;
            state <= S_SCAN;
          end
        end
        S_SCAN: begin
          cnt <= cnt + 1'b1;
          pend_idx <= cnt;
          rd_pend <= 1'b1;
          if (rd_pend) begin
            cum <= cum_next;
            if (cum_next > r_q) begin
              res_err <= 1'b0;
              rd_pend <= 1'b0;
              if (op_q == OP_START) begin
                res_first <= RES_W'(pend_idx[PW-1:AW]);
                res_second <= RES_W'(pend_idx[AW-1:0]);
                cur_pair <= pend_idx;
              end else begin
                res_first <= RES_W'(cur_pair[AW-1:0]);
                res_second <= RES_W'(pend_idx[AW-1:0]);
                cur_pair <= {cur_pair[AW-1:0], pend_idx[AW-1:0]};
              end
              state <= S_EMIT;
            end
          end
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        S_SPARE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_EMIT) && (!m_tvalid || m_tready)) begin
      m_tdata <= {{(M_DATA_W - 2 * RES_W){1'b0}}, res_second, res_first};
      m_tuser <= res_err;
    end
  end

endmodule

FILE: rtl/mpss_chk.sv
module mpss_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic [mpss_pkg::S_DATA_W-1:0] s_tdata,
  input logic [mpss_pkg::OP_W-1:0]     s_tuser,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [mpss_pkg::M_DATA_W-1:0] m_tdata,
  input logic                          m_tuser
);
  import mpss_pkg::*;

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid && !s_tready)
    else $error("activity right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tdata[2*RES_W-1:0] == '0)
    else $error("error result carries residues");

  a_train_silent: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == OP_TRAIN) && !m_tvalid |=> !m_tvalid)
    else $error("training request produced a result");

  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == OP_START || s_tuser == OP_NEXT) |=> !s_tready)
    else $error("sampling request did not hold off input");

endmodule

bind markov_pair_sequence_sampler mpss_chk u_mpss_chk (.*);
